// ===== src/positional_array_list_engine_top_defines.svh =====
// assertion macros for the positional array list engine
// used by the top level only; no other dependencies
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pal_pkg.sv =====
// shared types and constants for the positional array list engine
// no dependencies
package pal_pkg;

    localparam int unsigned DEPTH_DEF      = 128;
    localparam int unsigned ELEM_WIDTH_DEF = 32;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned LEN_W  = 8;
    localparam int unsigned CAP_W  = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_WRITE      = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } t_cell_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] target;   // zero-based index of the addressed entry
    } t_cell_ctl;

endpackage

// ===== src/pal_cell.sv =====
// one storage cell of the list row: holds one element, trades with neighbors
// depends on pal_pkg
module pal_cell #(
    parameter int unsigned ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF,
    parameter int unsigned IDX        = 0
) (
    input  logic                  i_clk,
    input  pal_pkg::t_cell_ctl    i_ctl,
    input  logic [ELEM_WIDTH-1:0] i_wdata,
    input  logic [ELEM_WIDTH-1:0] i_left,   // entry below, taken on shift up
    input  logic [ELEM_WIDTH-1:0] i_right,  // entry above, taken on shift down
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic [ELEM_WIDTH-1:0] o_rd      // own entry when addressed, else zero
);
    import pal_pkg::*;

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] n_data;
    logic                  w_hit;
    logic                  w_above;

    assign w_hit   = (32'(i_ctl.target) == IDX);
    assign w_above = (32'(i_ctl.target) <  IDX);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_WRITE: begin
                if (w_hit) n_data = i_wdata;
            end
            CELL_SHIFT_UP: begin
                if (w_above)    n_data = i_left;
                else if (w_hit) n_data = i_wdata;
            end
            CELL_SHIFT_DOWN: begin
                if (w_above || w_hit) n_data = i_right;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = w_hit ? r_data : '0;

endmodule

// ===== src/positional_array_list_engine_top.sv =====
// top level of the positional array list engine: command decode, cell row,
// read-out and result register; depends on pal_pkg, pal_cell and the defines header
//
// Fixed-capacity ordered list with one-based positions, held in a row of DEPTH
// cells, one element per cell. Commands are get, set, insert before, delete and
// clear; insert and delete shift the whole row up or down at the same clock edge,
// each cell taking its neighbor's entry, so one input word is accepted per cycle
// as long as the result register is free or being drained in the same cycle.
// The element read by get or delete is picked by an and-or tree across the cells.
// Each command returns one result word with status, value read and new length.
// The capacity register limits the list below DEPTH; it is written through the
// cfg channel, which is always ready, and should be written only while idle.
// Element storage has no reset; reset clears length and valid, loads the capacity.
`include "positional_array_list_engine_top_defines.svh"

module positional_array_list_engine_top #(
    parameter int unsigned DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int unsigned ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    // result words
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // status[1:0], read_value[33:2], length[41:34]
    // capacity register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data        // capacity[7:0]
);
    import pal_pkg::*;

    // control state
    logic [LEN_W-1:0] r_count;
    logic [CAP_W-1:0] r_capacity;
    logic             r_out_valid;

    // result register
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_rd;
    logic [LEN_W-1:0]  r_len;

    logic              w_accept;
    t_cmd              w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_value;

    logic              w_pos_ok;
    logic              w_pos_ok_ins;
    logic              w_full;
    t_status           w_status;
    logic              w_rd_sel;
    logic [LEN_W-1:0]  n_count;
    t_cell_ctl         w_ctl;

    logic [ELEM_WIDTH-1:0] w_wdata;
    logic [ELEM_WIDTH-1:0] w_rd_elem;
    logic [VAL_W-1:0]      w_rd32;
    logic [ELEM_WIDTH-1:0] w_cell [DEPTH];
    logic [ELEM_WIDTH-1:0] w_cell_rd [DEPTH];
    logic [DEPTH-1:0]      w_rd_col [ELEM_WIDTH];

    assign w_cmd   = t_cmd'(i_s_axis_tuser);
    assign w_pos   = i_s_axis_tdata[POS_W-1:0];
    assign w_value = i_s_axis_tdata[POS_W +: VAL_W];

    // the result register frees up when its word is taken in this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // position checks; count never exceeds DEPTH, so pos <= count keeps it in range
    assign w_pos_ok     = (w_pos != '0) && (w_pos <= r_count);
    assign w_pos_ok_ins = (w_pos != '0) && ({1'b0, w_pos} <= ({1'b0, r_count} + 9'd1));
    // full against the capacity register limited to the row length
    assign w_full       = (r_count >= r_capacity) || (32'(r_count) >= DEPTH);

    always_comb begin
        w_status   = ST_OK;
        w_rd_sel   = 1'b0;
        n_count    = r_count;
        w_ctl.op   = CELL_HOLD;
        w_ctl.target = w_pos - 8'd1;
        unique case (w_cmd)
            CMD_GET: begin
                if (w_pos_ok) w_rd_sel = 1'b1;
                else          w_status = ST_BADPOS;
            end
            CMD_SET: begin
                if (w_pos_ok) w_ctl.op = CELL_WRITE;
                else          w_status = ST_BADPOS;
            end
            CMD_INSERT: begin
                // full is checked before the position
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_ok_ins) begin
                    w_ctl.op = CELL_SHIFT_UP;
                    n_count  = r_count + 8'd1;
                end else begin
                    w_status = ST_BADPOS;
                end
            end
            CMD_DELETE: begin
                if (w_pos_ok) begin
                    w_ctl.op = CELL_SHIFT_DOWN;
                    w_rd_sel = 1'b1;
                    n_count  = r_count - 8'd1;
                end else begin
                    w_status = ST_BADPOS;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unknown command: no change, ok status
            end
        endcase
        if (!w_accept) w_ctl.op = CELL_HOLD;
    end

    // element width conversion on store and read
    generate
        if (ELEM_WIDTH <= VAL_W) begin : g_narrow
            assign w_wdata = w_value[ELEM_WIDTH-1:0];
            assign w_rd32  = VAL_W'($signed(w_rd_elem));
        end else begin : g_wide
            assign w_wdata = ELEM_WIDTH'($signed(w_value));
            assign w_rd32  = w_rd_elem[VAL_W-1:0];
        end
    endgenerate

    // cell row, each cell wired to its two neighbors
    genvar gi, gb;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ELEM_WIDTH-1:0] w_left;
            logic [ELEM_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[gi+1];
            end
            pal_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_wdata (w_wdata),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_cell[gi]),
                .o_rd    (w_cell_rd[gi])
            );
            for (gb = 0; gb < ELEM_WIDTH; gb++) begin : g_col
                assign w_rd_col[gb][gi] = w_cell_rd[gi][gb];
            end
        end
        // only the addressed cell drives nonzero, so an or per bit selects it
        for (gb = 0; gb < ELEM_WIDTH; gb++) begin : g_rd_or
            assign w_rd_elem[gb] = |w_rd_col[gb];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_capacity <= i_cfg_data;
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_rd     <= w_rd_sel ? w_rd32 : '0;
            r_len    <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_len, r_rd, r_status};

    // checks
    `PAL_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, (w_accept && (w_cmd == CMD_CLEAR)), (r_count == '0), "clear did not empty the list")
    `PAL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, (w_accept && (w_ctl.op == CELL_SHIFT_UP)), (r_count == $past(r_count) + 8'd1), "insert did not grow the list")
    `PAL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, (32'(r_count) <= DEPTH), "length beyond the cell row")

endmodule

// ===== sim/positional_array_list_engine_top_test.sv =====
// self-checking testbench for positional_array_list_engine_top: directed table, then random
// command phases under several capacities; depends on pal_pkg and the top level only
module positional_array_list_engine_top_test;
    import pal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = int'(DEPTH_DEF);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 137;
    localparam int HOLD_AT_ITEM = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int SHOWN_ERRORS = 10;
    localparam int NUM_ROWS     = 29;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} t_mix;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic [LEN_W-1:0] length;
    } t_list_result;

    typedef struct packed {
        logic             is_cfg;
        logic [CAP_W-1:0] cap;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             typed;   // want holds the expected result, else predict it
        t_list_result     want;
    } t_dir_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // position[7:0], value[39:8]
    logic [2:0]  i_s_axis_tuser  = '0;   // command[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;         // status[1:0], read_value[33:2], length[41:34]
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data      = '0;   // capacity[7:0]

    positional_array_list_engine_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the list
    logic [VAL_W-1:0] shadow_elems [LIST_DEPTH];
    int               shadow_len = 0;
    int               shadow_cap = int'(CAP_RESET);

    t_list_result pending_results [$];

    int cycle_count    = 0;
    int items_sent     = 0;
    int cfg_writes     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int n_ok           = 0;
    int n_badpos       = 0;
    int n_full         = 0;
    int burst_left     = 0;
    int rx_cycle       = 0;
    int hold_left      = 0;
    logic hold_off     = 1'b0;
    logic hold_done    = 1'b0;

    // directed words: boundaries of position and value, every command, full and bad position
    t_dir_row directed_rows [NUM_ROWS] = '{
        '{1'b0, 8'd0,   CMD_GET,    8'd1,   32'h0,        1'b1, '{ST_BADPOS, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_DELETE, 8'd0,   32'h0,        1'b1, '{ST_BADPOS, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_SET,    8'd1,   32'h5,        1'b1, '{ST_BADPOS, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd2,   32'h9,        1'b1, '{ST_BADPOS, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd1,   32'h7fffffff, 1'b1, '{ST_OK, 32'h0, 8'd1}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd1,   32'h80000000, 1'b1, '{ST_OK, 32'h0, 8'd2}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd3,   32'hffffffff, 1'b1, '{ST_OK, 32'h0, 8'd3}},
        '{1'b0, 8'd0,   CMD_GET,    8'd1,   32'h0,        1'b1, '{ST_OK, 32'h80000000, 8'd3}},
        '{1'b0, 8'd0,   CMD_GET,    8'd3,   32'h0,        1'b1, '{ST_OK, 32'hffffffff, 8'd3}},
        '{1'b0, 8'd0,   CMD_GET,    8'd4,   32'h0,        1'b1, '{ST_BADPOS, 32'h0, 8'd3}},
        '{1'b0, 8'd0,   CMD_GET,    8'd255, 32'h0,        1'b1, '{ST_BADPOS, 32'h0, 8'd3}},
        '{1'b0, 8'd0,   CMD_SET,    8'd2,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_GET,    8'd2,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd2,   32'h12345678, 1'b0, '0},
        '{1'b0, 8'd0,   CMD_DELETE, 8'd1,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_DELETE, 8'd3,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_RSVD5,  8'd1,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_RSVD7,  8'd255, 32'hffffffff, 1'b0, '0},
        '{1'b0, 8'd0,   CMD_CLEAR,  8'd0,   32'h0,        1'b1, '{ST_OK, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_DELETE, 8'd1,   32'h0,        1'b1, '{ST_BADPOS, 32'h0, 8'd0}},
        '{1'b1, 8'd0,   CMD_GET,    8'd0,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd1,   32'haaaa,     1'b1, '{ST_FULL, 32'h0, 8'd0}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd0,   32'h1,        1'b1, '{ST_FULL, 32'h0, 8'd0}},
        '{1'b1, 8'd1,   CMD_GET,    8'd0,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd1,   32'h55555555, 1'b1, '{ST_OK, 32'h0, 8'd1}},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd1,   32'h2,        1'b1, '{ST_FULL, 32'h0, 8'd1}},
        '{1'b1, 8'd255, CMD_GET,    8'd0,   32'h0,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_INSERT, 8'd2,   32'h1,        1'b0, '0},
        '{1'b0, 8'd0,   CMD_RSVD6,  8'd0,   32'h0,        1'b0, '0}
    };

    logic [CAP_W-1:0] phase_caps [NUM_PHASES] = '{
        8'd128, 8'd255, 8'd16, 8'd0, 8'd1, 8'd3, 8'd200, 8'd128, 8'd0, 8'd64, 8'd128, 8'd2
    };
    t_mix phase_mix [NUM_PHASES] = '{
        MIX_GROW, MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_BALANCED, MIX_BALANCED,
        MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_GROW, MIX_GROW, MIX_BALANCED
    };

    // applies one command to the shadow list and returns the result it must produce
    function automatic t_list_result predict_list_result(input logic [CMD_W-1:0] cmd,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [VAL_W-1:0] val);
        t_list_result res;
        int eff_cap;
        int p;
        res.status = ST_OK;
        res.value  = '0;
        eff_cap    = (shadow_cap < LIST_DEPTH) ? shadow_cap : LIST_DEPTH;
        p          = int'(pos);
        case (cmd)
            CMD_GET, CMD_SET, CMD_DELETE: begin
                if (p < 1 || p > shadow_len) begin
                    res.status = ST_BADPOS;
                end else if (cmd == CMD_GET) begin
                    res.value = shadow_elems[p-1];
                end else if (cmd == CMD_SET) begin
                    shadow_elems[p-1] = val;
                end else begin
                    res.value = shadow_elems[p-1];
                    for (int i = p; i < shadow_len; i++) shadow_elems[i-1] = shadow_elems[i];
                    shadow_len--;
                end
            end
            CMD_INSERT: begin
                // full is decided before the position is looked at
                if (shadow_len >= eff_cap) begin
                    res.status = ST_FULL;
                end else if (p < 1 || p > shadow_len + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = shadow_len; i >= p; i--) shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[p-1] = val;
                    shadow_len++;
                end
            end
            CMD_CLEAR: shadow_len = 0;
            default: ;
        endcase
        res.length = LEN_W'(shadow_len);
        return res;
    endfunction

    // offers one word in bursts with random gaps and records what it must return
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val, input logic typed,
                             input t_list_result typed_want);
        t_list_result predicted;
        int gap;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            gap = $urandom_range(8, 1);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 60)
                                                     : $urandom_range(12, 1);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {val, pos};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = predict_list_result(cmd, pos, val);
        pending_results.push_back(typed ? typed_want : predicted);
        burst_left--;
        items_sent++;
    endtask

    // capacity changes only with the block drained
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_cap = int'(cap);
        cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // one long receiver hold-off so the result register fills and input stalls
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) hold_off <= 1'b0;
        end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: ready pattern is chosen by bits [8:7] of rx_cycle; result check on each accepted word
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        logic ready_next;
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:7])
            2'd0: ready_next = 1'b1;
            2'd1: ready_next = 1'($urandom_range(0, 1));
            2'd2: ready_next = (rx_cycle[1:0] == 2'd0);
            default: ready_next = ($urandom_range(0, 9) != 0);
        endcase
        i_m_axis_tready <= ready_next && !hold_off;

        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status = t_status'(o_m_axis_tdata[1:0]);
            got.value  = o_m_axis_tdata[33:2];
            got.length = o_m_axis_tdata[41:34];
            results_seen <= results_seen + 1;
            case (got.status)
                ST_OK:     n_ok     <= n_ok + 1;
                ST_BADPOS: n_badpos <= n_badpos + 1;
                ST_FULL:   n_full   <= n_full + 1;
                default: ;
            endcase
            if (pending_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < SHOWN_ERRORS)
                    $display("unexpected result word: status %0d value %h length %0d",
                             got.status, got.value, got.length);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.value !== want.value ||
                    got.length !== want.length) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < SHOWN_ERRORS)
                        $display("mismatch at result %0d: expected st %0d val %h len %0d, %s",
                                 results_seen, want.status, want.value, want.length,
                                 $sformatf("got st %0d val %h len %0d",
                                           got.status, got.value, got.length));
                end
            end
        end
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int ins_top, get_top, set_top, del_top, clr_top;
        int pick, shape, room;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                write_capacity(directed_rows[r].cap);
            else
                send_item(directed_rows[r].cmd, directed_rows[r].pos, directed_rows[r].val,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // phase 8 takes a random capacity, any 8-bit value
            write_capacity((ph == 8) ? CAP_W'($urandom_range(0, 255)) : phase_caps[ph]);
            case (phase_mix[ph])
                MIX_GROW:     begin ins_top = 70; get_top = 82; set_top = 90;
                                    del_top = 95; clr_top = 95; end
                MIX_SHRINK:   begin ins_top = 15; get_top = 33; set_top = 43;
                                    del_top = 90; clr_top = 93; end
                default:      begin ins_top = 32; get_top = 50; set_top = 63;
                                    del_top = 90; clr_top = 93; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < ins_top)      cmd = CMD_INSERT;
                else if (pick < get_top) cmd = CMD_GET;
                else if (pick < set_top) cmd = CMD_SET;
                else if (pick < del_top) cmd = CMD_DELETE;
                else if (pick < clr_top) cmd = CMD_CLEAR;
                else if (pick < 97)      cmd = CMD_W'($urandom_range(CMD_RSVD7, CMD_RSVD5));
                else                     cmd = CMD_W'($urandom_range(0, 7));

                // mostly legal positions, some at the edges, some anywhere
                room  = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
                shape = $urandom_range(0, 19);
                if (shape < 16 && room > 0) pos = POS_W'($urandom_range(room, 1));
                else if (shape == 16)       pos = POS_W'(room);
                else if (shape == 17)       pos = POS_W'(room + 1);
                else                        pos = POS_W'($urandom_range(0, 255));

                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: val = 32'h0;
                        1: val = 32'h7fffffff;
                        2: val = 32'h80000000;
                        default: val = 32'hffffffff;
                    endcase
                end else begin
                    val = $urandom();
                end
                send_item(cmd, pos, val, 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // wait on so that a stray word would still be seen
        repeat (8) @(posedge i_clk);

        $display("sent %0d command words under %0d capacity settings, %0d results compared",
                 items_sent, cfg_writes, results_seen);
        $display("statuses: %0d ok, %0d bad position, %0d full; %0d mismatches",
                 n_ok, n_badpos, n_full, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
